// ----- hdl/hsha_pkg.sv -----
package hsha_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int CNT_W = LENGTH_BITS - 3;

    localparam int CQ_AW = 1;
    localparam int CQ_DEPTH = 2 ** CQ_AW;

    localparam logic [1:0] OP_KEY = 2'd0;
    localparam logic [1:0] OP_MSG = 2'd1;
    localparam logic [1:0] OP_TAG = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] tag_word;
        logic [2:0]  word_index;
        logic        verdict;
        logic        final_word;
    } t_out_item;

    typedef struct packed {
        logic [1:0] op;
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
    } t_cmd;

    localparam logic [0:7][31:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_s0(input logic [31:0] a);
        return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] e);
        return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

// ----- hdl/hsha_cmdq.sv -----
module hsha_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsha_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output hsha_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    hsha_pkg::t_cmd r_mem [hsha_pkg::CQ_DEPTH];
    logic [hsha_pkg::CQ_AW-1:0] r_wp;
    logic [hsha_pkg::CQ_AW-1:0] r_rp;
    logic [hsha_pkg::CQ_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (hsha_pkg::CQ_AW + 1)'(hsha_pkg::CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/hsha_front.sv -----
module hsha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hsha_pkg::t_in_item i_item,
    output logic              o_push,
    output hsha_pkg::t_cmd    o_cmd,
    input  logic              i_full
);

    localparam logic [1:0] PH_KEY = 2'd0;
    localparam logic [1:0] PH_MSG = 2'd1;
    localparam logic [1:0] PH_TAG = 2'd2;

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic       w_acc;
    logic       w_take;
    logic       w_live;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_live  = i_item.has_byte || i_item.last;

    always_comb begin
        n_phase   = r_phase;
        w_take    = 1'b0;
        o_cmd.op  = hsha_pkg::OP_KEY;
        o_cmd.has_byte  = i_item.has_byte;
        o_cmd.data_byte = i_item.data_byte;
        o_cmd.last      = i_item.last;
        case (i_item.kind)
            hsha_pkg::OP_KEY: begin
                if (r_phase == PH_KEY || r_phase == PH_TAG) begin
                    w_take  = w_live;
                    n_phase = i_item.last ? PH_MSG : PH_KEY;
                end
            end
            hsha_pkg::OP_MSG: begin
                if (r_phase == PH_MSG) begin
                    o_cmd.op = hsha_pkg::OP_MSG;
                    w_take   = w_live;
                    n_phase  = i_item.last ? PH_TAG : PH_MSG;
                end
            end
            hsha_pkg::OP_TAG: begin
                if (r_phase == PH_TAG) begin
                    o_cmd.op = hsha_pkg::OP_TAG;
                    w_take   = w_live;
                    n_phase  = i_item.last ? PH_KEY : PH_TAG;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push = w_acc && w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY;
        end else if (w_acc) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ----- hdl/hsha_back.sv -----
module hsha_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  hsha_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output hsha_pkg::t_out_item o_result
);

    localparam int CW = hsha_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CST   = 4'd1;
    localparam logic [3:0] S_RND   = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_KABS  = 4'd4;
    localparam logic [3:0] S_KLAST = 4'd5;
    localparam logic [3:0] S_KDIG  = 4'd6;
    localparam logic [3:0] S_IPAD  = 4'd7;
    localparam logic [3:0] S_MLAST = 4'd8;
    localparam logic [3:0] S_OPAD  = 4'd9;
    localparam logic [3:0] S_OMSG  = 4'd10;
    localparam logic [3:0] S_TAGO  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_VERD  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;
    localparam logic [3:0] S_FIN2  = 4'd15;

    logic [3:0]        r_st;
    logic [3:0]        r_ret;
    logic [3:0]        r_fret;
    logic [5:0]        r_rnd;
    logic [CW-1:0]     r_cnt;
    logic              r_tl;
    logic [6:0]        r_kfill;
    logic [7:0]        r_acc;
    logic [5:0]        r_ecnt;
    logic [2:0]        r_widx;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              r_ov;
    hsha_pkg::t_out_item r_out;

    logic [0:7][31:0]  r_h;
    logic [0:7][31:0]  r_v;
    logic [0:15][31:0] r_w;
    logic [0:15][31:0] r_key;
    logic [0:7][31:0]  r_inner;
    logic [0:7][31:0]  r_tag;

    logic [5:0]        w_pos;
    logic [63:0]       w_len;
    logic [0:15][31:0] w_pad;
    logic [0:15][31:0] w_kpad;
    logic [7:0]        w_padc;
    logic [0:7][31:0]  w_hsum;
    logic [31:0]       w_t1;
    logic [31:0]       w_t2;
    logic [31:0]       w_wnew;
    logic              w_ofree;
    logic              w_lt64;
    logic [7:0]        w_tbyte;

    assign o_pop    = (r_st == S_IDLE) && !i_empty;
    assign o_valid  = r_ov;
    assign o_result = r_out;
    assign w_ofree  = !r_ov || !i_stall;
    assign w_pos    = r_cnt[5:0];
    assign w_len    = 64'({r_cnt, 3'b000});
    assign w_lt64   = !(|r_cnt[CW-1:6]);
    assign w_tbyte  = r_tag[r_ecnt[4:2]][{~r_ecnt[1:0], 3'b000} +: 8];

    always_comb begin
        case (r_st)
            S_IPAD:  w_padc = 8'h36;
            S_OPAD:  w_padc = 8'h5c;
            default: w_padc = 8'h00;
        endcase
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
                if ((4 * i + j) < int'(w_pos)) begin
                    w_pad[i][8*(3-j) +: 8] = r_w[i][8*(3-j) +: 8];
                end else if ((4 * i + j) == int'(w_pos)) begin
                    w_pad[i][8*(3-j) +: 8] = 8'h80;
                end else begin
                    w_pad[i][8*(3-j) +: 8] = 8'h00;
                end
                if ((4 * i + j) < int'(r_kfill)) begin
                    w_kpad[i][8*(3-j) +: 8] = r_key[i][8*(3-j) +: 8] ^ w_padc;
                end else begin
                    w_kpad[i][8*(3-j) +: 8] = w_padc;
                end
            end
        end
        if (w_pos < 6'd56) begin
            w_pad[14] = w_len[63:32];
            w_pad[15] = w_len[31:0];
        end
        for (int i = 0; i < 8; i++) begin
            w_hsum[i] = r_h[i] + r_v[i];
        end
    end

    assign w_t1 = r_v[7] + hsha_pkg::big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + hsha_pkg::ROUND_K[r_rnd] + r_w[0];
    assign w_t2 = hsha_pkg::big_s0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_wnew = hsha_pkg::small_s1(r_w[14]) + r_w[9] + hsha_pkg::small_s0(r_w[1]) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_tl    <= 1'b0;
            r_kfill <= '0;
            r_acc   <= '0;
            r_ecnt  <= '0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (!i_empty) begin
                        case (i_cmd.op)
                            hsha_pkg::OP_KEY: begin
                                r_st <= i_cmd.last ? S_KLAST : S_IDLE;
                                if (i_cmd.has_byte) begin
                                    if (!r_tl && w_lt64) begin
                                        r_key[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] <=
                                            i_cmd.data_byte;
                                        r_cnt   <= r_cnt + 1'b1;
                                        r_kfill <= r_kfill + 1'b1;
                                    end else if (!r_tl) begin
                                        r_tl   <= 1'b1;
                                        r_h    <= hsha_pkg::IV;
                                        r_w    <= w_kpad;
                                        r_byte <= i_cmd.data_byte;
                                        r_last <= i_cmd.last;
                                        r_ret  <= S_KABS;
                                        r_st   <= S_CST;
                                    end else begin
                                        r_w[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] <=
                                            i_cmd.data_byte;
                                        r_cnt <= r_cnt + 1'b1;
                                        if (w_pos == 6'd63) begin
                                            r_ret <= i_cmd.last ? S_KLAST : S_IDLE;
                                            r_st  <= S_CST;
                                        end
                                    end
                                end
                            end
                            hsha_pkg::OP_MSG: begin
                                r_st <= i_cmd.last ? S_MLAST : S_IDLE;
                                if (i_cmd.has_byte) begin
                                    r_w[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] <=
                                        i_cmd.data_byte;
                                    r_cnt <= r_cnt + 1'b1;
                                    if (w_pos == 6'd63) begin
                                        r_ret <= i_cmd.last ? S_MLAST : S_IDLE;
                                        r_st  <= S_CST;
                                    end
                                end
                            end
                            hsha_pkg::OP_TAG: begin
                                r_st <= i_cmd.last ? S_VERD : S_IDLE;
                                if (i_cmd.has_byte) begin
                                    if (!r_ecnt[5]) begin
                                        r_acc <= r_acc | (w_tbyte ^ i_cmd.data_byte);
                                    end
                                    if (r_ecnt != 6'd63) begin
                                        r_ecnt <= r_ecnt + 1'b1;
                                    end
                                end
                            end
                            default: begin
                                r_st <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CST: begin
                    r_v   <= r_h;
                    r_rnd <= '0;
                    r_st  <= S_RND;
                end
                S_RND: begin
                    r_v <= {w_t1 + w_t2, r_v[0], r_v[1], r_v[2],
                            r_v[3] + w_t1, r_v[4], r_v[5], r_v[6]};
                    r_w   <= {r_w[1:15], w_wnew};
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) begin
                        r_st <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_h  <= w_hsum;
                    r_st <= r_ret;
                end
                S_KABS: begin
                    r_w[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] <= r_byte;
                    r_cnt <= r_cnt + 1'b1;
                    r_st  <= r_last ? S_KLAST : S_IDLE;
                end
                S_KLAST: begin
                    r_fret <= S_KDIG;
                    r_st   <= r_tl ? S_FIN : S_IPAD;
                end
                S_KDIG: begin
                    r_key[0:7] <= r_h;
                    r_kfill    <= 7'd32;
                    r_st       <= S_IPAD;
                end
                S_IPAD: begin
                    r_h   <= hsha_pkg::IV;
                    r_w   <= w_kpad;
                    r_cnt <= CW'(64);
                    r_ret <= S_IDLE;
                    r_st  <= S_CST;
                end
                S_MLAST: begin
                    r_fret <= S_OPAD;
                    r_st   <= S_FIN;
                end
                S_OPAD: begin
                    r_inner <= r_h;
                    r_h     <= hsha_pkg::IV;
                    r_w     <= w_kpad;
                    r_ret   <= S_OMSG;
                    r_st    <= S_CST;
                end
                S_OMSG: begin
                    r_w   <= {r_inner, 32'h80000000, 32'd0, 32'd0, 32'd0,
                              32'd0, 32'd0, 32'd0, 32'd768};
                    r_ret <= S_TAGO;
                    r_st  <= S_CST;
                end
                S_TAGO: begin
                    r_tag   <= r_h;
                    r_cnt   <= '0;
                    r_tl    <= 1'b0;
                    r_kfill <= '0;
                    r_acc   <= '0;
                    r_ecnt  <= '0;
                    r_widx  <= '0;
                    r_st    <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_ofree) begin
                        r_ov              <= 1'b1;
                        r_out.result_kind <= 1'b0;
                        r_out.tag_word    <= r_h[r_widx];
                        r_out.word_index  <= r_widx;
                        r_out.verdict     <= 1'b0;
                        r_out.final_word  <= (r_widx == 3'd7);
                        r_widx            <= r_widx + 1'b1;
                        if (r_widx == 3'd7) begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                S_VERD: begin
                    if (w_ofree) begin
                        r_ov              <= 1'b1;
                        r_out.result_kind <= 1'b1;
                        r_out.tag_word    <= '0;
                        r_out.word_index  <= '0;
                        r_out.verdict     <= (r_ecnt == 6'd32) && (r_acc == 8'd0);
                        r_out.final_word  <= 1'b1;
                        r_cnt             <= '0;
                        r_tl              <= 1'b0;
                        r_kfill           <= '0;
                        r_acc             <= '0;
                        r_ecnt            <= '0;
                        r_st              <= S_IDLE;
                    end
                end
                S_FIN: begin
                    r_w   <= w_pad;
                    r_ret <= (w_pos < 6'd56) ? r_fret : S_FIN2;
                    r_st  <= S_CST;
                end
                S_FIN2: begin
                    r_w   <= {32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                              32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                              w_len[63:32], w_len[31:0]};
                    r_ret <= r_fret;
                    r_st  <= S_CST;
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/hmac_sha256_engine_core.sv -----
// Key and message bytes: one per cycle while the command queue is not full; every full
// 64-byte block is compressed in turn (load, 64 rounds of the single round unit, chain add).
// Closing the message runs up to four compressions, then 8 tag words at one per cycle while
// the output is not stalled; a key over 64 bytes adds up to two compressions at its close.
// Reset is synchronous, active low: clears control, phase and counters; hash and
// buffer stores are undefined until written.
module hmac_sha256_engine_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hsha_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output hsha_pkg::t_out_item o_result
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    hsha_pkg::t_cmd w_cmd_in;
    hsha_pkg::t_cmd w_cmd_out;

    hsha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in),
        .i_full  (w_full)
    );

    hsha_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    hsha_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

// ----- hdl/hsha_chk.sv -----
module hsha_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input hsha_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input hsha_pkg::t_out_item o_result
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("input item dropped or changed while stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result item dropped or changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_verd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.result_kind |->
            o_result.final_word && (o_result.tag_word == 32'd0) &&
            (o_result.word_index == 3'd0))
        else $error("malformed verdict item");

    a_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.result_kind |->
            (o_result.final_word == (o_result.word_index == 3'd7)) && !o_result.verdict)
        else $error("malformed tag word item");

endmodule

bind hmac_sha256_engine_core hsha_chk u_hsha_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
